FILE: sv/bgrlab_pkg.sv
// ----------------------------------------------------------------------------
// bgrlab_pkg
// Shared constants for the BGR to log l-alpha-beta converter.
// ----------------------------------------------------------------------------
package bgrlab_pkg;

    localparam int IN_FRAC_BITS_DEF = 8;
    localparam int IN_W             = 16;
    localparam int OUT_W            = 18;
    localparam int COEF_W           = 16;
    localparam int LMS_W            = IN_W + COEF_W + 2;
    localparam int MANT_W           = 32;
    localparam int FRAC_STEPS       = 16;
    localparam int LOG2_W           = 24;
    localparam int LN_W             = 24;

    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
    localparam logic [15:0] INV_SQRT6_Q16 = 16'd26755;
    localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

    // Rows give L, M, S; columns give red, green, blue weights in Q0.16.
    localparam logic [15:0] COEF [3][3] = '{
        '{16'd24976, 16'd37899, 16'd2635},
        '{16'd12891, 16'd47474, 16'd5125},
        '{16'd1579,  16'd8441,  16'd55339}
    };

endpackage

FILE: sv/bgr_to_log_lab_converter_top.sv
// ----------------------------------------------------------------------------
// bgr_to_log_lab_converter_top
// Pipelined BGR to logarithmic l-alpha-beta converter, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Channel | Signals                          | Direction
// in      | in_valid/in_ready, blue/green/red | request into the block
// out     | out_valid/out_ready, lum_l/...    | request out of the block
//
// One pixel enters per clock unless the output stalls; the stages are matrix,
// normalize, sixteen squaring stages, scale, mix, output scale and saturation.
// Reset clears all stage valid bits. A stall at the output freezes the whole
// pipeline in place; in_ready is high whenever the last stage is empty or its
// result is taken in the same cycle.
// ----------------------------------------------------------------------------
module bgr_to_log_lab_converter_top
    import bgrlab_pkg::*;
#(
    parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [IN_W-1:0]         blue,
    input  logic [IN_W-1:0]         green,
    input  logic [IN_W-1:0]         red,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [OUT_W-1:0] lum_l,
    output logic signed [OUT_W-1:0] alpha_ch,
    output logic signed [OUT_W-1:0] beta_ch
);

    localparam int LMS_FRAC = IN_FRAC_BITS + 16;
    localparam int NST      = FRAC_STEPS;
    localparam int PW       = 6;
    localparam int NS       = NST + 10;

    logic adv;
    logic [NS-1:0] v_reg;

    assign adv       = out_ready || !v_reg[NS-1];
    assign in_ready  = adv;
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    // Stage 1: input registers.
    logic [IN_W-1:0] b_reg, g_reg, r_reg;
    // Stage 2: products.
    logic [COEF_W+IN_W-1:0] prod_reg [3][3];
    // Stage 3: LMS sums.
    logic [LMS_W-1:0] x_reg [3];
    // Stage 4: floor flag, position and mantissa.
    logic            flr_reg [3];
    logic [PW-1:0]   p_reg [3];
    logic [MANT_W-1:0] z_reg [NST+1][3];
    logic [NST-1:0]  fr_reg [NST+1][3];
    logic            flp_reg [NST+1][3];
    logic [PW-1:0]   pp_reg [NST+1][3];
    // After squaring: log2 and ln products.
    logic signed [LOG2_W-1:0] l2_reg [3];
    logic signed [LOG2_W+30:0] lnp_reg [3];
    logic signed [LN_W-1:0] ln_reg [3];
    logic signed [LN_W+2:0] sum_reg [3];
    logic signed [LN_W+2+17:0] op_reg [3];
    logic signed [OUT_W-1:0] o_reg [3];

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] h;
        h = 64'sd1 <<< (s - 1);
        rnd_shift = (v + h) >>> s;
    endfunction

    // Floor-test and top-bit search, combinational per lane.
    logic            flr_c [3];
    logic [PW-1:0]   p_c [3];
    logic [MANT_W-1:0] z_c [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            // The shifted terms add up to x times 10000.
            flr_c[k] = ({x_reg[k], 13'd0} + {x_reg[k], 10'd0}
                        + {x_reg[k], 9'd0} + {x_reg[k], 8'd0} + {x_reg[k], 4'd0})
                       < (48'd1 << LMS_FRAC);
            p_c[k] = '0;
            for (int i = 0; i < LMS_W; i++)
            begin
                if (x_reg[k][i])
                begin
                    p_c[k] = PW'(i);
                end
            end
            if (p_c[k] >= PW'(30))
            begin
                z_c[k] = MANT_W'(x_reg[k] >> (p_c[k] - PW'(30)));
            end
            else
            begin
                z_c[k] = MANT_W'(x_reg[k] << (PW'(30) - p_c[k]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg <= blue;
            g_reg <= green;
            r_reg <= red;
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k][0] <= COEF[k][0] * r_reg;
                prod_reg[k][1] <= COEF[k][1] * g_reg;
                prod_reg[k][2] <= COEF[k][2] * b_reg;
                x_reg[k] <= LMS_W'(prod_reg[k][0]) + LMS_W'(prod_reg[k][1])
                            + LMS_W'(prod_reg[k][2]);
                z_reg[0][k]   <= z_c[k];
                fr_reg[0][k]  <= '0;
                flp_reg[0][k] <= flr_c[k];
                pp_reg[0][k]  <= p_c[k];
                for (int s = 0; s < NST; s++)
                begin
                    logic [63:0] sq;
                    logic [MANT_W:0] zz;
                    sq = 64'(z_reg[s][k]) * 64'(z_reg[s][k]);
                    zz = (MANT_W+1)'(sq >> 30);
                    if (zz[MANT_W-1] || zz[MANT_W])
                    begin
                        z_reg[s+1][k]  <= MANT_W'(zz >> 1);
                        fr_reg[s+1][k] <= {fr_reg[s][k][NST-2:0], 1'b1};
                    end
                    else
                    begin
                        z_reg[s+1][k]  <= MANT_W'(zz);
                        fr_reg[s+1][k] <= {fr_reg[s][k][NST-2:0], 1'b0};
                    end
                    flp_reg[s+1][k] <= flp_reg[s][k];
                    pp_reg[s+1][k]  <= pp_reg[s][k];
                end
                if (flp_reg[NST][k])
                begin
                    l2_reg[k] <= '0;
                end
                else
                begin
                    l2_reg[k] <= LOG2_W'(($signed({1'b0, pp_reg[NST][k]})
                                 - (PW+1)'(LMS_FRAC)) * 65536)
                                 + LOG2_W'({1'b0, fr_reg[NST][k]});
                end
                lnp_reg[k] <= (LOG2_W+31)'(l2_reg[k]) * $signed({1'b0, LN2_Q30});
                ln_reg[k]  <= LN_W'(rnd_shift(64'(lnp_reg[k]), 30));
            end
            sum_reg[0] <= (LN_W+3)'(ln_reg[0]) + (LN_W+3)'(ln_reg[1])
                          + (LN_W+3)'(ln_reg[2]);
            sum_reg[1] <= (LN_W+3)'(ln_reg[0]) + (LN_W+3)'(ln_reg[1])
                          - ((LN_W+3)'(ln_reg[2]) <<< 1);
            sum_reg[2] <= (LN_W+3)'(ln_reg[0]) - (LN_W+3)'(ln_reg[1]);
            op_reg[0] <= (LN_W+20)'(sum_reg[0]) * $signed({1'b0, INV_SQRT3_Q16});
            op_reg[1] <= (LN_W+20)'(sum_reg[1]) * $signed({1'b0, INV_SQRT6_Q16});
            op_reg[2] <= (LN_W+20)'(sum_reg[2]) * $signed({1'b0, INV_SQRT2_Q16});
            for (int k = 0; k < 3; k++)
            begin
                logic signed [63:0] v;
                v = rnd_shift(64'(op_reg[k]), 20);
                if (v > 64'sd131071)
                begin
                    o_reg[k] <= 18'sd131071;
                end
                else if (v < -64'sd131072)
                begin
                    o_reg[k] <= -18'sd131072;
                end
                else
                begin
                    o_reg[k] <= OUT_W'(v);
                end
            end
        end
    end

    assign lum_l    = o_reg[0];
    assign alpha_ch = o_reg[1];
    assign beta_ch  = o_reg[2];

endmodule
